@@ hw/rtl/qrs_pkg.sv @@
// Package with shared widths for the quadratic root solver.
package qrs_pkg;
    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_BITS = 34;
endpackage

@@ hw/rtl/qrs_sqrt.sv @@
// Pipelined fixed-point square root, one result bit per stage.
module qrs_sqrt #(
    parameter int IN_BITS = 34,
    parameter int FRAC_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [IN_BITS-1:0]              i_radicand,
    input  logic [TAG_BITS-1:0]             i_tag,
    output logic                            o_valid,
    output logic [(IN_BITS+1)/2+FRAC_BITS-1:0] o_root,
    output logic [TAG_BITS-1:0]             o_tag
);
    localparam int RB = (IN_BITS + 1) / 2 + FRAC_BITS;
    localparam int XB = 2 * RB;
    localparam int REMB = RB + 2;

    logic [RB:0]            r_v;
    logic [XB-1:0]          r_x    [RB+1];
    logic [RB-1:0]          r_root [RB+1];
    logic [REMB-1:0]        r_rem  [RB+1];
    logic [TAG_BITS-1:0]    r_tag  [RB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[RB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= XB'(i_radicand) << (2 * FRAC_BITS);
        r_root[0] <= '0;
        r_rem[0]  <= '0;
        r_tag[0]  <= i_tag;
    end

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [REMB-1:0] n_rem;
        logic [REMB-1:0] n_trial;
        always_comb begin
            n_rem   = {r_rem[k][REMB-3:0], r_x[k][XB-1:XB-2]};
            n_trial = {r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_x[k+1]   <= {r_x[k][XB-3:0], 2'b00};
            r_tag[k+1] <= r_tag[k];
            if (n_rem >= n_trial) begin
                r_rem[k+1]  <= n_rem - n_trial;
                r_root[k+1] <= {r_root[k][RB-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= {r_root[k][RB-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_root  = r_root[RB];
    assign o_tag   = r_tag[RB];
endmodule

@@ hw/rtl/qrs_div.sv @@
// Pipelined restoring divider, signed result truncated toward zero.
module qrs_div #(
    parameter int NUM_BITS = 60,
    parameter int DEN_BITS = 17,
    parameter int TAG_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic signed [DEN_BITS-1:0] i_den,
    input  logic [TAG_BITS-1:0]        i_tag,
    output logic                       o_valid,
    output logic signed [NUM_BITS:0]   o_quot,
    output logic [TAG_BITS-1:0]        o_tag
);
    localparam int N = NUM_BITS;
    localparam int RW = DEN_BITS + 1;

    logic [N:0]            r_v;
    logic [N-1:0]          r_q   [N+1];
    logic [RW-1:0]         r_rem [N+1];
    logic [DEN_BITS-1:0]   r_den [N+1];
    logic                  r_neg [N+1];
    logic [TAG_BITS-1:0]   r_tag [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0]   <= i_num[N-1] ? N'(-i_num) : N'(i_num);
        r_den[0] <= i_den[DEN_BITS-1] ? DEN_BITS'(-i_den) : DEN_BITS'(i_den);
        r_neg[0] <= i_num[N-1] ^ i_den[DEN_BITS-1];
        r_rem[0] <= '0;
        r_tag[0] <= i_tag;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_den;
        always_comb begin
            n_rem = {r_rem[k][RW-2:0], r_q[k][N-1]};
            n_den = {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_tag[k+1] <= r_tag[k];
            if (n_rem >= n_den) begin
                r_rem[k+1] <= n_rem - n_den;
                r_q[k+1]   <= {r_q[k][N-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_rem;
                r_q[k+1]   <= {r_q[k][N-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quot  = r_neg[N] ? -$signed({1'b0, r_q[N]}) : $signed({1'b0, r_q[N]});
    assign o_tag   = r_tag[N];
endmodule

@@ hw/rtl/quadratic_root_solver_top.sv @@
// Top level of the quadratic root solver: discriminant, square root, dividers, output.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------------------
//  request  | i_coef_a, i_coef_b, i_coef_c              | start high, busy low
//  result   | o_roots_real, o_first_value,              | o_valid strobe, one cycle,
//           | o_second_value, o_degenerate              | cannot be held off
//
// One transaction is accepted every cycle; busy is tied low since nothing stalls.
// The pipeline holds three discriminant stages, the square root pipeline of
// (2*COEF_BITS+4)/2+FRAC_BITS stages, the divider of COEF_BITS+FRAC_BITS+4 stages,
// plus the output register.
// Reset clears all valid bits; data registers need none.
module quadratic_root_solver_top #(
    parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [15:0]                 i_coef_a,
    input  logic signed [15:0]                 i_coef_b,
    input  logic signed [15:0]                 i_coef_c,
    output logic                               o_valid,
    output logic                               o_roots_real,
    output logic signed [qrs_pkg::OUT_BITS-1:0] o_first_value,
    output logic signed [qrs_pkg::OUT_BITS-1:0] o_second_value,
    output logic                               o_degenerate
);
    import qrs_pkg::*;

    // Discriminant magnitude is held in 2*COEF_BITS+2 bits.
    localparam int DB = 2 * COEF_BITS + 2;
    localparam int SB = (DB + 1) / 2 + FRAC_BITS;
    // Numerator -b*2^F +- s in signed form.
    localparam int NB = COEF_BITS + FRAC_BITS + 3;
    localparam int DENB = COEF_BITS + 2;
    localparam int QB = NB + 1;

    assign busy = 1'b0;

    // Stage 1 registers the low COEF_BITS bits of the coefficients, stage 2 forms the products.
    logic                        r_v1, r_v2, r_v3;
    logic signed [COEF_BITS-1:0] r_a1, r_b1;
    logic signed [2*COEF_BITS-1:0] r_bb2, r_ac2;
    logic signed [COEF_BITS-1:0] r_a2, r_b2;
    logic signed [DB:0]          r_d3;
    logic signed [COEF_BITS-1:0] r_a3, r_b3;
    logic signed [COEF_BITS-1:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1  <= i_coef_a[COEF_BITS-1:0];
        r_b1  <= i_coef_b[COEF_BITS-1:0];
        r_c1  <= i_coef_c[COEF_BITS-1:0];
        r_bb2 <= r_b1 * r_b1;
        r_ac2 <= r_a1 * r_c1;
        r_a2  <= r_a1;
        r_b2  <= r_b1;
        r_d3  <= (DB+1)'(r_bb2) - ((DB+1)'(r_ac2) <<< 2);
        r_a3  <= r_a2;
        r_b3  <= r_b2;
    end

    // Square root on |d|; coefficients ride along in the tag.
    logic [DB-1:0]  n_mag;
    logic           sq_v;
    logic [SB-1:0]  sq_root;
    logic [2*COEF_BITS:0] sq_tag;
    assign n_mag = r_d3[DB] ? DB'(-r_d3) : DB'(r_d3);

    qrs_sqrt #(.IN_BITS(DB), .FRAC_BITS(FRAC_BITS), .TAG_BITS(2*COEF_BITS+1)) u_sqrt (
        .i_clk, .i_rst_n, .i_valid(r_v3), .i_radicand(n_mag),
        .i_tag({~r_d3[DB], r_a3, r_b3}),
        .o_valid(sq_v), .o_root(sq_root), .o_tag(sq_tag)
    );

    // Build numerators and denominator.
    logic signed [COEF_BITS-1:0] n_sa, n_sb;
    logic                        n_real;
    logic signed [NB-1:0]        n_nb, n_s, n_num1, n_num2;
    logic signed [DENB-1:0]      n_den;
    assign n_real = sq_tag[2*COEF_BITS];
    assign n_sa   = sq_tag[2*COEF_BITS-1:COEF_BITS];
    assign n_sb   = sq_tag[COEF_BITS-1:0];
    assign n_nb   = -(NB'(n_sb) <<< FRAC_BITS);
    assign n_s    = $signed(NB'(sq_root));
    assign n_num1 = n_real ? n_nb + n_s : n_nb;
    assign n_num2 = n_real ? n_nb - n_s : n_s;
    // Zero a divides by one; the result is forced to zero at the end.
    assign n_den  = (n_sa == '0) ? DENB'(1) : (DENB'(n_sa) <<< 1);

    logic                    d1_v, d2_v;
    logic signed [QB-1:0]    d1_q, d2_q;
    logic [1:0]              d1_tag, d2_tag;

    qrs_div #(.NUM_BITS(NB), .DEN_BITS(DENB), .TAG_BITS(2)) u_div1 (
        .i_clk, .i_rst_n, .i_valid(sq_v), .i_num(n_num1), .i_den(n_den),
        .i_tag({n_real, n_sa == '0}), .o_valid(d1_v), .o_quot(d1_q), .o_tag(d1_tag)
    );
    qrs_div #(.NUM_BITS(NB), .DEN_BITS(DENB), .TAG_BITS(2)) u_div2 (
        .i_clk, .i_rst_n, .i_valid(sq_v), .i_num(n_num2), .i_den(n_den),
        .i_tag({n_real, n_sa == '0}), .o_valid(d2_v), .o_quot(d2_q), .o_tag(d2_tag)
    );

    // Saturate to the output width.
    function automatic logic signed [OUT_BITS-1:0] f_sat(input logic signed [QB-1:0] q);
        logic signed [QB+OUT_BITS-1:0] w;
        logic signed [QB+OUT_BITS-1:0] hi;
        logic signed [QB+OUT_BITS-1:0] lo;
        w  = (QB+OUT_BITS)'(q);
        hi = (QB+OUT_BITS)'({1'b0, {(OUT_BITS-1){1'b1}}});
        lo = -hi - 1;
        if (w > hi) return OUT_BITS'(hi);
        if (w < lo) return OUT_BITS'(lo);
        return OUT_BITS'(w);
    endfunction

    logic r_ov;
    logic r_real, r_deg;
    logic signed [OUT_BITS-1:0] r_f, r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= d1_v & d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg  <= d1_tag[0];
        r_real <= d1_tag[1] & ~d1_tag[0];
        r_f    <= d1_tag[0] ? '0 : f_sat(d1_q);
        r_s    <= d2_tag[0] ? '0 : f_sat(d2_q);
    end

    assign o_valid        = r_ov;
    assign o_roots_real   = r_real;
    assign o_first_value  = r_f;
    assign o_second_value = r_s;
    assign o_degenerate   = r_deg;
endmodule

@@ dv/quadratic_root_solver_top_test.sv @@
// Self-checking testbench for the quadratic root solver top level.
`timescale 1ns / 1ps

module quadratic_root_solver_top_test;

    localparam int FRAC = qrs_pkg::FRAC_BITS_DEF;
    localparam int OW = qrs_pkg::OUT_BITS;
    // Pipeline depth from the top-level header: discriminant, square root, divider, output register.
    localparam int PIPE_DEPTH = 74;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic roots_real;
        logic signed [OW-1:0] first_value;
        logic signed [OW-1:0] second_value;
        logic degenerate;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] i_coef_a = '0;
    logic signed [15:0] i_coef_b = '0;
    logic signed [15:0] i_coef_c = '0;
    logic o_valid;
    logic o_roots_real;
    logic signed [OW-1:0] o_first_value;
    logic signed [OW-1:0] o_second_value;
    logic o_degenerate;

    t_roots pending_roots[$];
    int mismatch_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int complex_count = 0;
    int quiet_cycles = 0;
    bit idling_on = 1'b1;

    quadratic_root_solver_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .o_valid(o_valid), .o_roots_real(o_roots_real),
        .o_first_value(o_first_value), .o_second_value(o_second_value),
        .o_degenerate(o_degenerate)
    );

    always #4 i_clk = ~i_clk;

    // floor(sqrt(x)) by the restoring digit method; x is wide enough to hold
    // |d| shifted up by twice the fraction bits.
    function automatic logic [47:0] floor_sqrt(input logic [95:0] x);
        logic [95:0] rem;
        logic [95:0] root;
        logic [95:0] bitv;
        rem = x;
        root = '0;
        bitv = 96'd1 << 94;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[47:0];
    endfunction

    // Truncating division followed by saturation to the output width.
    function automatic logic signed [OW-1:0] scaled_quotient(input longint num,
                                                             input longint den);
        longint q;
        longint hi;
        hi = (longint'(1) <<< (OW - 1)) - 1;
        q = num / den;
        if (q > hi) q = hi;
        if (q < -hi - 1) q = -hi - 1;
        return q[OW-1:0];
    endfunction

    function automatic t_roots solve_roots(input logic signed [15:0] ca,
                                           input logic signed [15:0] cb,
                                           input logic signed [15:0] cc);
        t_roots r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint neg_b;
        longint s;
        a = longint'(ca);
        b = longint'(cb);
        c = longint'(cc);
        r = '{1'b0, '0, '0, 1'b0};
        if (a == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        disc = b * b - 4 * a * c;
        neg_b = -b * (longint'(1) <<< FRAC);
        if (disc >= 0) begin
            s = longint'(floor_sqrt(96'(disc) << (2 * FRAC)));
            r.roots_real = 1'b1;
            r.first_value = scaled_quotient(neg_b + s, 2 * a);
            r.second_value = scaled_quotient(neg_b - s, 2 * a);
        end else begin
            s = longint'(floor_sqrt(96'(-disc) << (2 * FRAC)));
            r.first_value = scaled_quotient(neg_b, 2 * a);
            r.second_value = scaled_quotient(s, 2 * a);
        end
        return r;
    endfunction

    // Leaves start low for a random burst, only while idling is enabled.
    task automatic maybe_pause();
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Offers one coefficient set and returns once it has been taken. Start is
    // left high so back-to-back transactions need no extra edge.
    task automatic send_coefs(input logic signed [15:0] ca,
                              input logic signed [15:0] cb,
                              input logic signed [15:0] cc);
        maybe_pause();
        start = 1'b1;
        i_coef_a = ca;
        i_coef_b = cb;
        i_coef_c = cc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_roots.push_back(solve_roots(ca, cb, cc));
        sent_count++;
        @(negedge i_clk);
    endtask

    // Result checker and watchdog, both sampled on the rising edge.
    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d idle cycles", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
            if (o_valid) begin
                if (pending_roots.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transaction at %0t", $realtime);
                end else begin
                    want = pending_roots.pop_front();
                    checked_count++;
                    if (!want.roots_real && !want.degenerate) complex_count++;
                    if (o_roots_real !== want.roots_real ||
                        o_first_value !== want.first_value ||
                        o_second_value !== want.second_value ||
                        o_degenerate !== want.degenerate) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Result %0d: expected real=%b v1=%0d v2=%0d deg=%b,",
                                     checked_count, want.roots_real, want.first_value,
                                     want.second_value, want.degenerate,
                                     " got real=%b v1=%0d v2=%0d deg=%b",
                                     o_roots_real, o_first_value, o_second_value,
                                     o_degenerate);
                    end
                end
            end
        end
    end

    // Corner cases: zero a, field extremes, double root, complex roots with
    // either sign of a, and the largest discriminants of both signs.
    task automatic test_directed();
        send_coefs(16'sd0, 16'sd5, 16'sd3);
        send_coefs(16'sd0, 16'sh8000, 16'sh7fff);
        send_coefs(16'sd1, -16'sd2, 16'sd1);
        send_coefs(16'sd1, 16'sd0, -16'sd4);
        send_coefs(16'sd1, 16'sd0, 16'sd1);
        send_coefs(-16'sd1, 16'sd0, -16'sd1);
        send_coefs(-16'sd3, 16'sd7, 16'sd11);
        send_coefs(16'sd2, 16'sd3, 16'sd5);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
        send_coefs(16'sh8000, 16'sh8000, 16'sh7fff);
        send_coefs(16'sh7fff, 16'sd0, 16'sh7fff);
        send_coefs(16'sh8000, 16'sd0, 16'sh8000);
        send_coefs(16'sd1, 16'sh8000, 16'sd0);
        send_coefs(-16'sd1, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sd1, 16'sd1, 16'sd1);
        send_coefs(16'shffff, 16'shffff, 16'shffff);
        send_coefs(16'sd4, 16'sd4, 16'sd1);
    endtask

    // Random coefficients: full range mostly, with small values and a zero a
    // now and then so that every branch is visited often.
    task automatic test_random(input int count);
        logic signed [15:0] ca;
        logic signed [15:0] cb;
        logic signed [15:0] cc;
        repeat (count) begin
            ca = 16'($urandom);
            cb = 16'($urandom);
            cc = 16'($urandom);
            case ($urandom_range(0, 5))
                0: begin
                    ca = $signed(16'($urandom_range(0, 16))) - 16'sd8;
                    cb = $signed(16'($urandom_range(0, 64))) - 16'sd32;
                    cc = $signed(16'($urandom_range(0, 64))) - 16'sd32;
                end
                1: ca = '0;
                default: ;
            endcase
            send_coefs(ca, cb, cc);
        end
    endtask

    // Back-to-back stream with no gaps on the request side.
    task automatic test_streaming(input int count);
        idling_on = 1'b0;
        test_random(count);
    endtask

    initial begin
        int drain;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(300);
        test_streaming(100);
        start = 1'b0;
        drain = 0;
        while (pending_roots.size() != 0 && drain < PIPE_DEPTH * 20) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("Sent %0d coefficient sets, checked %0d results (%0d complex).",
                 sent_count, checked_count, complex_count);
        $display("Covered zero a, extreme coefficients, double roots and idle bursts.");
        if (mismatch_count == 0 && pending_roots.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, pending_roots.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver_top.sv
dv/quadratic_root_solver_top_test.sv
